// ===== rtl/skd_pkg.sv =====
// skd_pkg: shared types and constants of the spectral kick detector.
// No dependencies; imported by skd_regs, skd_ctrl, skd_dp and the top level.
`default_nettype none
package skd_pkg;

    localparam int DEF_MAX_BANDS  = 32;
    localparam int DEF_HIST_DEPTH = 64;

    localparam int ADDR_W = 5;

    localparam logic [2:0] REG_KICK_ENABLE   = 3'd0;
    localparam logic [2:0] REG_END_BAND      = 3'd1;
    localparam logic [2:0] REG_HISTORY_LEN   = 3'd2;
    localparam logic [2:0] REG_RATIO_MARGIN  = 3'd3;
    localparam logic [2:0] REG_PEAK_FLOOR    = 3'd4;
    localparam logic [2:0] REG_REFRACTORY_US = 3'd5;

    typedef struct packed {
        logic        kick_enable;
        logic [5:0]  end_band;
        logic [6:0]  history_len;
        logic [15:0] ratio_margin;
        logic [15:0] peak_floor;
        logic [23:0] refractory_us;
    } t_cfg;

    typedef struct packed {
        logic accept;
        logic mul;
        logic div_step;
        logic finish;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic frame_ok;
        logic hist_zero;
        logic div_last;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

// ===== rtl/skd_ram.sv =====
// skd_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module skd_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 64
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic                                  i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/skd_regs.sv =====
// skd_regs: APB-style configuration register file.
// Depends on skd_pkg.
`default_nettype none
module skd_regs
    import skd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output t_cfg                   o_cfg
);

    t_cfg       r_cfg;
    logic [2:0] idx;
    logic       wr;

    assign idx = paddr[ADDR_W-1:2];
    assign wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kick_enable   <= 1'b1;
            r_cfg.end_band      <= 6'd4;
            r_cfg.history_len   <= 7'd8;
            r_cfg.ratio_margin  <= '0;
            r_cfg.peak_floor    <= '0;
            r_cfg.refractory_us <= '0;
        end else if (wr) begin
            case (idx)
                REG_KICK_ENABLE:   r_cfg.kick_enable   <= pwdata[0];
                REG_END_BAND:      r_cfg.end_band      <= pwdata[5:0];
                REG_HISTORY_LEN:   r_cfg.history_len   <= pwdata[6:0];
                REG_RATIO_MARGIN:  r_cfg.ratio_margin  <= pwdata[15:0];
                REG_PEAK_FLOOR:    r_cfg.peak_floor    <= pwdata[15:0];
                REG_REFRACTORY_US: r_cfg.refractory_us <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_KICK_ENABLE:   prdata = {31'd0, r_cfg.kick_enable};
            REG_END_BAND:      prdata = {26'd0, r_cfg.end_band};
            REG_HISTORY_LEN:   prdata = {25'd0, r_cfg.history_len};
            REG_RATIO_MARGIN:  prdata = {16'd0, r_cfg.ratio_margin};
            REG_PEAK_FLOOR:    prdata = {16'd0, r_cfg.peak_floor};
            REG_REFRACTORY_US: prdata = {8'd0, r_cfg.refractory_us};
            default:           prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ===== rtl/skd_ctrl.sv =====
// skd_ctrl: frame sequencer for the kick detector (band intake, multiply,
// iterative divide, decision, result hand-off). Depends on skd_pkg.
`default_nettype none
module skd_ctrl
    import skd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_s_valid,
    input  wire logic i_s_last,
    input  t_status   i_status,
    output logic      o_s_ready,
    output t_cmd      o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_FIN  = 5'b01000,
        ST_LOAD = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.accept = i_s_valid;
                if (i_s_valid && i_s_last) begin
                    n_state = i_status.frame_ok ? ST_MUL : ST_LOAD;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = i_status.hist_zero ? ST_FIN : ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_LOAD;
            end
            ST_LOAD: begin
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_s_ready = (r_state == ST_IDLE);

endmodule
`default_nettype wire

// ===== rtl/skd_dp.sv =====
// skd_dp: kick detector datapath: band accumulators, power history ring,
// ratio divider, decision logic, output register. Depends on skd_pkg, skd_ram.
`default_nettype none
module skd_dp
    import skd_pkg::*;
#(
    parameter int MAX_BANDS  = DEF_MAX_BANDS,
    parameter int HIST_DEPTH = DEF_HIST_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  t_cfg             i_cfg,
    input  t_cmd             i_cmd,
    input  wire logic [15:0] i_band_value,
    input  wire logic        i_last,
    input  wire logic        i_analysis_valid,
    input  wire logic [19:0] i_frame_dt_us,
    output t_status          o_status,
    input  wire logic        i_m_ready,
    output logic             o_m_valid,
    output logic             o_kick_fired,
    output logic [15:0]      o_spike_ratio,
    output logic [19:0]      o_held_us,
    output logic [23:0]      o_cooldown_us
);

    localparam int CW  = $clog2(MAX_BANDS + 1);
    localparam int PW  = 16 + CW;
    localparam int LW  = $clog2(HIST_DEPTH + 1);
    localparam int HW  = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int TW  = PW + LW;
    localparam int NW  = PW + LW + 8;
    localparam int RW  = 18 + TW;
    localparam int DCW = $clog2(NW + 1);

    // frame accumulators and history state
    logic [PW-1:0]  r_sum;
    logic [15:0]    r_peak;
    logic [CW-1:0]  r_bcnt;
    logic [31:0]    r_since;
    logic [TW-1:0]  r_total;
    logic [LW-1:0]  r_count;
    logic [HW-1:0]  r_head;
    // latched frame
    logic [PW-1:0]  r_power;
    logic [15:0]    r_fpeak;
    logic [19:0]    r_dt;
    // multiply / divide
    logic [NW-1:0]  r_num;
    logic [NW-1:0]  r_quo;
    logic [TW-1:0]  r_rem;
    logic [DCW-1:0] r_dcnt;
    logic signed [RW-1:0] r_rhs;
    // result and output register
    logic           r_res_fire;
    logic [15:0]    r_res_ratio;
    logic [19:0]    r_res_held;
    logic [23:0]    r_res_cool;
    logic           r_out_valid;
    logic           r_out_fire;
    logic [15:0]    r_out_ratio;
    logic [19:0]    r_out_held;
    logic [23:0]    r_out_cool;

    logic [PW-1:0]  ram_rdata;
    logic [5:0]     endb;
    logic           take;
    logic [PW-1:0]  sum_now;
    logic [15:0]    peak_now;
    logic [32:0]    since_sum;
    logic [31:0]    since_now;
    logic [8:0]     hl9;
    logic [LW-1:0]  len;
    logic [9:0]     old_raw;
    logic [HW-1:0]  oldest;
    logic           evict;
    logic [TW:0]    trial;
    logic           trial_ge;
    logic [PW+LW-1:0] prod;
    logic signed [16:0]   thr17;
    logic signed [RW-1:0] thr_ext;
    logic signed [RW-1:0] tot_ext;
    logic signed [RW-1:0] lhs;
    logic           hist_zero;
    logic           ratio_ok;
    logic           fire;
    logic [15:0]    ratio;
    logic [31:0]    since_fin;
    logic [23:0]    cool;
    logic [HW-1:0]  head_next;

    always_comb begin
        endb      = (i_cfg.end_band == '0) ? 6'd1 : i_cfg.end_band;
        take      = (8'(r_bcnt) < 8'(endb)) && (8'(r_bcnt) < 8'(MAX_BANDS));
        sum_now   = r_sum + (take ? PW'(i_band_value) : '0);
        peak_now  = (take && (i_band_value > r_peak)) ? i_band_value : r_peak;
        since_sum = {1'b0, r_since} + 33'(i_frame_dt_us);
        since_now = since_sum[32] ? '1 : since_sum[31:0];

        hl9 = 9'(i_cfg.history_len);
        if (hl9 == '0) begin
            len = LW'(1);
        end else if (hl9 > 9'(HIST_DEPTH)) begin
            len = LW'(HIST_DEPTH);
        end else begin
            len = LW'(hl9);
        end

        old_raw = 10'(r_head) + 10'(HIST_DEPTH) - 10'(r_count);
        if (old_raw >= 10'(HIST_DEPTH)) begin
            old_raw = old_raw - 10'(HIST_DEPTH);
        end
        oldest = HW'(old_raw);
        evict  = (r_count >= len);
        head_next = (r_head == HW'(HIST_DEPTH - 1)) ? '0 : r_head + HW'(1);

        trial    = {r_rem, r_quo[NW-1]};
        trial_ge = (trial >= {1'b0, r_total});
        prod     = (PW+LW)'(r_power) * (PW+LW)'(len);

        thr17   = $signed({i_cfg.ratio_margin[15], i_cfg.ratio_margin})
                  + 17'sd256;
        thr_ext = RW'(thr17);
        tot_ext = RW'($signed({1'b0, r_total}));
        lhs     = RW'(r_num);

        hist_zero = (r_total == '0);
        if (hist_zero) begin
            ratio    = 16'd256;
            ratio_ok = i_cfg.ratio_margin[15] || (i_cfg.ratio_margin == '0);
        end else begin
            ratio    = (|r_quo[NW-1:16]) ? 16'hFFFF : r_quo[15:0];
            ratio_ok = (lhs >= r_rhs);
        end
        fire = ratio_ok && (r_fpeak >= i_cfg.peak_floor)
               && (r_since > 32'(i_cfg.refractory_us));
        since_fin = fire ? '0 : r_since;
        cool = (32'(i_cfg.refractory_us) > since_fin)
               ? 24'(32'(i_cfg.refractory_us) - since_fin) : '0;
    end

    skd_ram #(
        .WIDTH(PW),
        .DEPTH(HIST_DEPTH)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (i_cmd.finish),
        .i_waddr(r_head),
        .i_wdata(r_power),
        .i_re   (i_cmd.mul),
        .i_raddr(oldest),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_peak  <= '0;
            r_bcnt  <= '0;
            r_since <= '0;
            r_total <= '0;
            r_count <= '0;
            r_head  <= '0;
        end else begin
            if (i_cmd.accept && i_last) begin
                r_sum   <= '0;
                r_peak  <= '0;
                r_bcnt  <= '0;
                r_since <= since_now;
            end else if (i_cmd.accept) begin
                r_sum  <= sum_now;
                r_peak <= peak_now;
                if (8'(r_bcnt) < 8'(MAX_BANDS)) begin
                    r_bcnt <= r_bcnt + CW'(1);
                end
            end
            if (i_cmd.finish) begin
                r_total <= r_total - (evict ? TW'(ram_rdata) : '0) + TW'(r_power);
                r_count <= r_count - (evict ? LW'(1) : '0) + LW'(1);
                r_head  <= head_next;
                if (fire) begin
                    r_since <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_last) begin
            r_power <= sum_now;
            r_fpeak <= peak_now;
            r_dt    <= i_frame_dt_us;
            if (!o_status.frame_ok) begin
                r_res_fire  <= 1'b0;
                r_res_ratio <= '0;
                r_res_held  <= '0;
                r_res_cool  <= '0;
            end
        end
        if (i_cmd.mul) begin
            r_num  <= {prod, 8'h00};
            r_quo  <= {prod, 8'h00};
            r_rem  <= '0;
            r_dcnt <= DCW'(NW);
            r_rhs  <= thr_ext * tot_ext;
        end
        if (i_cmd.div_step) begin
            r_rem  <= trial_ge ? TW'(trial - {1'b0, r_total}) : TW'(trial);
            r_quo  <= {r_quo[NW-2:0], trial_ge};
            r_dcnt <= r_dcnt - DCW'(1);
        end
        if (i_cmd.finish) begin
            r_res_fire  <= fire;
            r_res_ratio <= ratio;
            r_res_held  <= fire ? r_dt : '0;
            r_res_cool  <= cool;
        end
        if (i_cmd.load) begin
            r_out_fire  <= r_res_fire;
            r_out_ratio <= r_res_ratio;
            r_out_held  <= r_res_held;
            r_out_cool  <= r_res_cool;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.frame_ok  = i_analysis_valid && i_cfg.kick_enable;
    assign o_status.hist_zero = hist_zero;
    assign o_status.div_last  = (r_dcnt == DCW'(1));
    assign o_status.out_free  = !r_out_valid || i_m_ready;

    assign o_m_valid     = r_out_valid;
    assign o_kick_fired  = r_out_fire;
    assign o_spike_ratio = r_out_ratio;
    assign o_held_us     = r_out_held;
    assign o_cooldown_us = r_out_cool;

    a_empty_ring_zero_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_total == '0))
        else $error("history total nonzero with empty ring");

    a_push_count_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> ((r_count != '0) && (r_count <= LW'(HIST_DEPTH))))
        else $error("ring count out of range after push");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> o_m_valid)
        else $error("result load did not raise output valid");

endmodule
`default_nettype wire

// ===== rtl/spectral_kick_detector.sv =====
// spectral_kick_detector: top level; joins register file, sequencer and datapath.
// Depends on skd_pkg, skd_regs, skd_ctrl, skd_dp (which holds skd_ram).
//
//  channel  | direction | beat qualifier             | payload
//  s_axis   | in        | s_axis_tvalid&s_axis_tready | band, dt, last, analysis valid
//  m_axis   | out       | m_axis_tvalid&m_axis_tready | ratio, held, cooldown, fired
//  apb      | in        | psel&penable&pwrite         | 6 config registers at 4*i
//
// The last beat of an invalid or disabled frame goes straight to the result load;
// else multiply runs, then, unless the history is empty, the one-bit-per-cycle
// restoring divider over NW bits (NW = numerator width, 37 at default parameters),
// then finish and load. Reset is synchronous, active low, and clears history state.
// A waiting result is held in the output register; band beats are still taken,
// and the next frame's result waits, with the input stalled, until that
// register frees.
`default_nettype none
module spectral_kick_detector
    import skd_pkg::*;
#(
    parameter int MAX_BANDS  = DEF_MAX_BANDS,
    parameter int HIST_DEPTH = DEF_HIST_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [39:0]       s_axis_tdata,  // band_value[15:0], frame_dt_us[35:16]
    input  wire logic              s_axis_tlast,  // last_band
    input  wire logic              s_axis_tuser,  // analysis_valid
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic      [63:0]       m_axis_tdata,  // spike_ratio[15:0], held_us[35:16],
                                                  // cooldown_us[59:36]
    output logic                   m_axis_tuser,  // kick_fired
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    t_cfg        cfg;
    t_cmd        cmd;
    t_status     status;
    logic [15:0] ratio;
    logic [19:0] held;
    logic [23:0] cool;

    assign pready = 1'b1;

    skd_regs u_regs (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .o_cfg  (cfg)
    );

    skd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_s_valid(s_axis_tvalid),
        .i_s_last (s_axis_tlast),
        .i_status (status),
        .o_s_ready(s_axis_tready),
        .o_cmd    (cmd)
    );

    skd_dp #(
        .MAX_BANDS (MAX_BANDS),
        .HIST_DEPTH(HIST_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_cmd           (cmd),
        .i_band_value    (s_axis_tdata[15:0]),
        .i_last          (s_axis_tlast),
        .i_analysis_valid(s_axis_tuser),
        .i_frame_dt_us   (s_axis_tdata[35:16]),
        .o_status        (status),
        .i_m_ready       (m_axis_tready),
        .o_m_valid       (m_axis_tvalid),
        .o_kick_fired    (m_axis_tuser),
        .o_spike_ratio   (ratio),
        .o_held_us       (held),
        .o_cooldown_us   (cool)
    );

    assign m_axis_tdata = {4'd0, cool, held, ratio};

endmodule
`default_nettype wire

// ===== tb/sv/kick_checker.sv =====
// kick_checker: watches the band, result and register channels of the kick detector,
// predicts one verdict per frame and compares it with each result beat.
// Depends on skd_pkg for the register indexes, the config layout and ADDR_W.
`timescale 1ns / 100ps
`default_nettype none
module kick_checker
    import skd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    input  wire logic              i_s_tready,
    input  wire logic [39:0]       i_s_tdata,   // band_value[15:0], frame_dt_us[35:16]
    input  wire logic              i_s_tlast,   // last_band
    input  wire logic              i_s_tuser,   // analysis_valid
    input  wire logic              i_m_tvalid,
    input  wire logic              i_m_tready,
    input  wire logic [63:0]       i_m_tdata,   // spike_ratio[15:0], held_us[35:16],
                                                // cooldown_us[59:36]
    input  wire logic              i_m_tuser,   // kick_fired
    input  wire logic              i_psel,
    input  wire logic              i_penable,
    input  wire logic              i_pwrite,
    input  wire logic [ADDR_W-1:0] i_paddr,
    input  wire logic [31:0]       i_pwdata,
    input  wire logic              i_pready,
    output int                     o_fail_count,
    output int                     o_pending
);

    localparam int MAX_BANDS  = DEF_MAX_BANDS;
    localparam int HIST_DEPTH = DEF_HIST_DEPTH;

    typedef struct packed {
        logic        fired;
        logic [15:0] ratio;
        logic [19:0] held;
        logic [23:0] cool;
    } t_verdict;

    t_cfg        cfg;
    logic [21:0] power_ring [HIST_DEPTH];
    logic [6:0]  ring_fill;
    logic [5:0]  ring_head;
    logic [27:0] window_total;
    logic [31:0] since_kick;
    logic [21:0] acc_sum;
    logic [15:0] acc_peak;
    logic [5:0]  band_idx;
    t_verdict    frame_verdicts [$];
    int          fails = 0;

    task automatic apply_reg_write(input logic [2:0] idx, input logic [31:0] data);
        case (idx)
            REG_KICK_ENABLE:   cfg.kick_enable   = data[0];
            REG_END_BAND:      cfg.end_band      = data[5:0];
            REG_HISTORY_LEN:   cfg.history_len   = data[6:0];
            REG_RATIO_MARGIN:  cfg.ratio_margin  = data[15:0];
            REG_PEAK_FLOOR:    cfg.peak_floor    = data[15:0];
            REG_REFRACTORY_US: cfg.refractory_us = data[23:0];
            default: ;
        endcase
    endtask

    task automatic push_power(input logic [21:0] power, input logic [6:0] win);
        logic [5:0] oldest;
        if (ring_fill >= win && ring_fill != 0) begin
            oldest = ring_head - ring_fill[5:0];
            window_total -= power_ring[oldest];
            ring_fill--;
        end
        power_ring[ring_head] = power;
        ring_head++;
        ring_fill++;
        window_total += power;
    endtask

    // One band beat: accumulate, and on the last band decide the frame.
    task automatic fold_band_beat(input logic [15:0] v, input logic last,
                                  input logic valid, input logic [19:0] dt);
        logic [6:0]  first_bands;
        logic [6:0]  win;
        logic [21:0] power;
        logic [15:0] peak;
        logic [63:0] scaled;
        logic [63:0] quot;
        logic [32:0] since_sum;
        longint      thr;
        logic        fire;
        t_verdict    r;
        first_bands = (cfg.end_band == 0) ? 7'd1 : 7'(cfg.end_band);
        if (band_idx < first_bands && band_idx < MAX_BANDS) begin
            acc_sum += v;
            if (v > acc_peak) acc_peak = v;
        end
        if (band_idx < MAX_BANDS) band_idx++;
        if (!last) return;

        power = acc_sum;
        peak = acc_peak;
        acc_sum = '0;
        acc_peak = '0;
        band_idx = '0;
        since_sum = {1'b0, since_kick} + dt;
        since_kick = since_sum[32] ? '1 : since_sum[31:0];
        r = '0;
        if (valid && cfg.kick_enable) begin
            if (cfg.history_len == 0) win = 7'd1;
            else if (cfg.history_len > HIST_DEPTH) win = 7'(HIST_DEPTH);
            else win = cfg.history_len;
            thr = longint'($signed(cfg.ratio_margin));
            if (window_total != 0) begin
                scaled = 64'(power) * win * 256;
                quot = scaled / window_total;
                r.ratio = (quot > 64'hFFFF) ? 16'hFFFF : quot[15:0];
                fire = longint'(scaled) >= (thr + 256) * longint'(window_total);
            end else begin
                r.ratio = 16'd256;
                fire = thr <= 0;
            end
            push_power(power, win);
            fire = fire && peak >= cfg.peak_floor && since_kick > cfg.refractory_us;
            if (fire) since_kick = '0;
            r.fired = fire;
            r.held = fire ? dt : '0;
            r.cool = (cfg.refractory_us > since_kick)
                     ? 24'(cfg.refractory_us - since_kick) : '0;
        end
        frame_verdicts.push_back(r);
    endtask

    task automatic flag_mismatch(input string what, input t_verdict want, input t_verdict seen);
        fails++;
        if (fails <= 10)
            $display({"%0t kick %s: exp fired=%0d ratio=%0d held=%0d cool=%0d,",
                      " got fired=%0d ratio=%0d held=%0d cool=%0d"},
                     $realtime, what, want.fired, want.ratio, want.held, want.cool,
                     seen.fired, seen.ratio, seen.held, seen.cool);
    endtask

    always @(posedge i_clk) begin
        t_verdict seen;
        t_verdict want;
        if (!i_rst_n) begin
            cfg = '0;
            cfg.kick_enable = 1'b1;
            cfg.end_band = 6'd4;
            cfg.history_len = 7'd8;
            ring_fill = '0;
            ring_head = '0;
            window_total = '0;
            since_kick = '0;
            acc_sum = '0;
            acc_peak = '0;
            band_idx = '0;
            frame_verdicts.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready)
                apply_reg_write(i_paddr[ADDR_W-1:2], i_pwdata);
            if (i_s_tvalid && i_s_tready)
                fold_band_beat(i_s_tdata[15:0], i_s_tlast, i_s_tuser, i_s_tdata[35:16]);
            if (i_m_tvalid && i_m_tready) begin
                seen.fired = i_m_tuser;
                seen.ratio = i_m_tdata[15:0];
                seen.held = i_m_tdata[35:16];
                seen.cool = i_m_tdata[59:36];
                if (frame_verdicts.size() == 0) begin
                    flag_mismatch("result beat with no frame pending", '0, seen);
                end else begin
                    want = frame_verdicts.pop_front();
                    if (seen !== want) flag_mismatch("mismatch", want, seen);
                end
            end
        end
        o_pending <= frame_verdicts.size();
        o_fail_count <= fails;
    end

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// tb_top: clock, reset, band frame stimulus, result back-pressure and register setup
// for spectral_kick_detector; the verdict comes from kick_checker's failure count.
// Depends on skd_pkg, spectral_kick_detector and kick_checker.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import skd_pkg::*;

    localparam int NUM_PHASES  = 12;
    localparam int PHASE_ITEMS = 110;
    localparam int HOLD_CYCLES = 400;

    typedef enum logic [2:0] {LVL_ZERO, LVL_QUIET, LVL_MID, LVL_LOUD, LVL_ANY} t_level;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [39:0]       s_axis_tdata = '0;   // band_value[15:0], frame_dt_us[35:16]
    logic              s_axis_tlast = 1'b0; // last_band
    logic              s_axis_tuser = 1'b0; // analysis_valid
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [63:0]       m_axis_tdata;        // spike_ratio[15:0], held_us[35:16],
                                            // cooldown_us[59:36]
    logic              m_axis_tuser;        // kick_fired
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    int fail_count;
    int pending_count;
    int burst_left;
    bit steady;
    int items_sent = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int rx_mode = 0;
    int rx_mode_left = 0;
    int rx_tick = 0;
    int phase;
    int phase_start;
    bit hold_done;
    bit pause_done;
    t_cfg plan;

    spectral_kick_detector uut (.*);

    kick_checker kick_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_axis_tvalid), .i_s_tready(s_axis_tready), .i_s_tdata(s_axis_tdata),
        .i_s_tlast(s_axis_tlast), .i_s_tuser(s_axis_tuser),
        .i_m_tvalid(m_axis_tvalid), .i_m_tready(m_axis_tready), .i_m_tdata(m_axis_tdata),
        .i_m_tuser(m_axis_tuser),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .i_pready(pready),
        .o_fail_count(fail_count), .o_pending(pending_count)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        #(20_000_000);
        $display("simulation failed");
        $finish;
    end

    // result back-pressure: mode changes now and then, long hold on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_served != hold_requests) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
                hold_served++;
            end else begin
                if (rx_mode_left == 0) begin
                    rx_mode = $urandom_range(0, 3);
                    rx_mode_left = $urandom_range(50, 300);
                end
                rx_mode_left--;
                rx_tick++;
                case (rx_mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= (rx_tick % 5) != 0;
                endcase
            end
        end
    end

    task automatic send_band(input logic [15:0] v, input logic last, input logic valid,
                             input logic [19:0] dt);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, dt, v};
        s_axis_tlast <= last;
        s_axis_tuser <= valid;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
        if (!steady) begin
            burst_left--;
            if (burst_left <= 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                burst_left = $urandom_range(1, 40);
            end
        end
    endtask

    function automatic logic [15:0] pick_band(input t_level level);
        case (level)
            LVL_ZERO:  return 16'd0;
            LVL_QUIET: return 16'($urandom_range(0, 15));
            LVL_MID:   return 16'($urandom_range(16'h0400, 16'h3FFF));
            LVL_LOUD:  return 16'($urandom_range(16'h8000, 16'hFFFF));
            default:   return 16'($urandom);
        endcase
    endfunction

    task automatic send_frame(input int n, input t_level level, input logic valid,
                              input logic [19:0] dt);
        for (int i = 0; i < n; i++) begin
            if (i == n - 1) send_band(pick_band(level), 1'b1, valid, dt);
            else send_band(pick_band(level), 1'b0, 1'($urandom_range(0, 1)),
                           20'($urandom));
        end
    endtask

    task automatic random_frame();
        int pick;
        int n;
        int r;
        t_level level;
        logic valid;
        logic [19:0] dt;
        pick = $urandom_range(0, 99);
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        r = $urandom_range(0, 99);
        if (r < 50) level = LVL_QUIET;
        else if (r < 75) level = LVL_LOUD;
        else if (r < 88) level = LVL_MID;
        else level = LVL_ANY;
        valid = $urandom_range(0, 9) != 0;
        r = $urandom_range(0, 99);
        if (r < 80) dt = 20'($urandom_range(1000, 60000));
        else if (r < 88) dt = '0;
        else if (r < 94) dt = 20'hFFFFF;
        else dt = 20'($urandom);
        if (pick < 8) n = $urandom_range(33, 48);
        else if (pick < 16) valid = 1'b0;
        else if (pick < 22) level = LVL_ZERO;
        send_frame(n, level, valid, dt);
    endtask

    // Stop offering bands and wait until every frame verdict has come out.
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int width, input logic [31:0] val);
        logic [31:0] word;
        word = (width >= 32) ? val : ((val & ((32'd1 << width) - 1)) | ($urandom() << width));
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 2'b00});
        pwdata <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        burst_left = $urandom_range(1, 40);

        // reset config: empty history, strict refractory, invalid frame, long frame
        send_band(16'h0000, 1'b1, 1'b1, 20'd0);
        send_band(16'h0000, 1'b1, 1'b1, 20'd5);
        send_band(16'hFFFF, 1'b0, 1'b1, 20'd0);
        send_band(16'h0001, 1'b0, 1'b1, 20'd0);
        send_band(16'h8000, 1'b0, 1'b1, 20'd0);
        send_band(16'h0000, 1'b1, 1'b1, 20'hFFFFF);
        send_band(16'h0001, 1'b0, 1'b1, 20'd0);
        send_band(16'h0002, 1'b0, 1'b1, 20'd0);
        send_band(16'h0003, 1'b0, 1'b1, 20'd0);
        send_band(16'h0004, 1'b0, 1'b1, 20'd0);
        send_band(16'hFFFF, 1'b0, 1'b1, 20'd0);
        send_band(16'hFFFF, 1'b1, 1'b1, 20'd100);
        send_band(16'hFFFF, 1'b0, 1'b0, 20'd0);
        send_band(16'hFFFF, 1'b1, 1'b0, 20'hFFFFF);
        send_band(16'h0001, 1'b1, 1'b1, 20'd7);
        for (int i = 0; i < 4; i++) send_band(16'hFFFF, i == 3, 1'b1, 20'd300);

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            settle_block();
            plan = '0;
            plan.kick_enable = (phase == 4) ? 1'b0 :
                               ((phase == 10) ? 1'($urandom_range(0, 1)) : 1'b1);
            case (phase % 6)
                0: plan.end_band = 6'd0;
                1: plan.end_band = 6'd1;
                2: plan.end_band = 6'd32;
                3: plan.end_band = 6'd63;
                default: plan.end_band = 6'($urandom_range(2, 31));
            endcase
            case (phase % 5)
                0: plan.history_len = 7'd0;
                1: plan.history_len = 7'd1;
                2: plan.history_len = 7'd64;
                3: plan.history_len = 7'd127;
                default: plan.history_len = 7'($urandom_range(2, 63));
            endcase
            case (phase % 7)
                0: plan.ratio_margin = 16'h8000;
                1: plan.ratio_margin = 16'h7FFF;
                2: plan.ratio_margin = 16'h0000;
                default: plan.ratio_margin = 16'(int'($urandom_range(0, 1024)) - 256);
            endcase
            case (phase % 4)
                0: plan.peak_floor = 16'h0000;
                1: plan.peak_floor = 16'hFFFF;
                default: plan.peak_floor = 16'($urandom_range(0, 16'h8000));
            endcase
            case (phase % 3)
                0: plan.refractory_us = 24'd0;
                1: plan.refractory_us = 24'hFFFFFF;
                default: plan.refractory_us = 24'($urandom_range(0, 200000));
            endcase
            write_reg(REG_KICK_ENABLE, 1, 32'(plan.kick_enable));
            write_reg(REG_END_BAND, 6, 32'(plan.end_band));
            write_reg(REG_HISTORY_LEN, 7, 32'(plan.history_len));
            write_reg(REG_RATIO_MARGIN, 16, 32'(plan.ratio_margin));
            write_reg(REG_PEAK_FLOOR, 16, 32'(plan.peak_floor));
            write_reg(REG_REFRACTORY_US, 24, 32'(plan.refractory_us));

            steady = 1'b0;
            hold_done = 1'b0;
            pause_done = 1'b0;
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                // results back up behind a held output while bands keep coming
                if (phase == 5 && !hold_done && items_sent - phase_start >= 20) begin
                    hold_requests <= hold_requests + 1;
                    steady = 1'b1;
                    hold_done = 1'b1;
                end
                if (phase == 8 && !pause_done
                    && items_sent - phase_start >= PHASE_ITEMS / 2) begin
                    settle_block();
                    pause_done = 1'b1;
                end
                random_frame();
            end
        end

        settle_block();
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== spectral_kick_detector.f =====
rtl/skd_pkg.sv
rtl/skd_ram.sv
rtl/skd_regs.sv
rtl/skd_ctrl.sv
rtl/skd_dp.sv
rtl/spectral_kick_detector.sv
tb/sv/kick_checker.sv
tb/sv/tb_top.sv
